// ----- src/tga_truecolor_to_rgba_stream_assert.svh -----
// Assertion macros shared by the TGA decoder RTL.
`ifndef TGA_TRUECOLOR_TO_RGBA_STREAM_ASSERT_SVH
`define TGA_TRUECOLOR_TO_RGBA_STREAM_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define TGA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("tga assertion failed: always");

// Antecedent implies consequent in the same cycle.
`define TGA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tga assertion failed: implication");

// Antecedent implies consequent in the next cycle.
`define TGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tga assertion failed: next cycle");

`endif

// ----- src/tga_pkg.sv -----
// Types and constants of the TGA true-color decoder.
package tga_pkg;

   localparam int unsigned HEADER_LAST    = 17;
   localparam logic [7:0]  OPAQUE         = 8'hff;
   localparam logic [7:0]  DEPTH_RGBA     = 8'd32;
   localparam logic [7:0]  DEPTH_RGB      = 8'd24;
   localparam logic [7:0]  MAP_NONE       = 8'd0;
   localparam logic [7:0]  TYPE_TRUECOLOR = 8'd2;
   localparam int unsigned QUEUE_DEPTH    = 4;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_ID,
      PH_PIXELS,
      PH_IGNORE
   } phase_type;

   typedef enum logic [2:0] {
      K_HEADER      = 3'd0,
      K_PIXEL       = 3'd1,
      K_UNSUPPORTED = 3'd2,
      K_TRUNCATED   = 3'd3,
      K_DONE        = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        final_pixel;
   } result_type;

   // Results produced by one input word: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ----- src/tga_decode_core.sv -----
// Header parser, pixel assembler and state registers of the TGA decoder.
`include "tga_truecolor_to_rgba_stream_assert.svh"
module tga_decode_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        file_byte,
   input  logic              end_of_file,
   output tga_pkg::push_type push
);
   import tga_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  header_index_ff, header_index_in;
   logic [7:0]  id_remaining_ff, id_remaining_in;
   logic [7:0]  color_map_kind_ff, color_map_kind_in;
   logic [7:0]  image_kind_ff, image_kind_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  depth_bits_ff, depth_bits_in;
   logic [31:0] pixels_remaining_ff, pixels_remaining_in;
   logic [1:0]  pixel_byte_index_ff, pixel_byte_index_in;
   logic [7:0]  pixel_bytes_ff [3];
   logic        store_pixel;
   logic [31:0] pixel_count;

   function automatic result_type make_result(kind_type k);
      result_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   function automatic push_type append(push_type p, result_type r);
      push_type q;
      q = p;
      if (p.count == 2'd0) begin
         q.first = r;
      end else begin
         q.second = r;
      end
      q.count = p.count + 2'd1;
      return q;
   endfunction

   assign pixel_count = 32'(width_ff) * 32'(height_ff);

   always_comb begin
      result_type r;
      logic       is_rgba;
      logic       supported;
      r                   = '0;
      phase_in            = phase_ff;
      header_index_in     = header_index_ff;
      id_remaining_in     = id_remaining_ff;
      color_map_kind_in   = color_map_kind_ff;
      image_kind_in       = image_kind_ff;
      width_in            = width_ff;
      height_in           = height_ff;
      depth_bits_in       = depth_bits_ff;
      pixels_remaining_in = pixels_remaining_ff;
      pixel_byte_index_in = pixel_byte_index_ff;
      store_pixel         = 1'b0;
      push                = '0;
      is_rgba             = (depth_bits_ff == DEPTH_RGBA);
      supported           = (color_map_kind_ff == MAP_NONE) &&
                            (image_kind_ff == TYPE_TRUECOLOR) &&
                            (is_rgba || depth_bits_ff == DEPTH_RGB);

      unique case (phase_ff)
         PH_HEADER: begin
            case (header_index_ff)
               5'd0:  id_remaining_in   = file_byte;
               5'd1:  color_map_kind_in = file_byte;
               5'd2:  image_kind_in     = file_byte;
               5'd12: width_in[7:0]     = file_byte;
               5'd13: width_in[15:8]    = file_byte;
               5'd14: height_in[7:0]    = file_byte;
               5'd15: height_in[15:8]   = file_byte;
               5'd16: depth_bits_in     = file_byte;
               default: ;
            endcase
            if (header_index_ff >= 5'(HEADER_LAST)) begin
               header_index_in = '0;
               if (!supported) begin
                  push     = append(push, make_result(K_UNSUPPORTED));
                  phase_in = PH_IGNORE;
               end else begin
                  r              = make_result(K_HEADER);
                  r.image_width  = width_ff;
                  r.image_height = height_ff;
                  push           = append(push, r);
                  pixels_remaining_in = pixel_count;
                  pixel_byte_index_in = '0;
                  if (id_remaining_ff != 8'd0) begin
                     phase_in = PH_ID;
                  end else if (pixel_count != 32'd0) begin
                     phase_in = PH_PIXELS;
                  end else begin
                     push     = append(push, make_result(K_DONE));
                     phase_in = PH_IGNORE;
                  end
               end
            end else begin
               header_index_in = header_index_ff + 5'd1;
            end
         end
         PH_ID: begin
            id_remaining_in = id_remaining_ff - 8'd1;
            if (id_remaining_ff == 8'd1) begin
               if (pixels_remaining_ff != 32'd0) begin
                  phase_in = PH_PIXELS;
               end else begin
                  push     = append(push, make_result(K_DONE));
                  phase_in = PH_IGNORE;
               end
            end
         end
         PH_PIXELS: begin
            store_pixel = (pixel_byte_index_ff != 2'd3);
            if (pixel_byte_index_ff >= (is_rgba ? 2'd3 : 2'd2)) begin
               // red arrives last in a 24-bit pixel, before alpha in a 32-bit one
               r             = make_result(K_PIXEL);
               r.red         = (pixel_byte_index_ff == 2'd2) ? file_byte : pixel_bytes_ff[2];
               r.green       = pixel_bytes_ff[1];
               r.blue        = pixel_bytes_ff[0];
               r.alpha       = is_rgba ? file_byte : OPAQUE;
               r.final_pixel = (pixels_remaining_ff == 32'd1);
               push          = append(push, r);
               pixel_byte_index_in = '0;
               pixels_remaining_in = pixels_remaining_ff - 32'd1;
               if (pixels_remaining_ff == 32'd1) begin
                  push     = append(push, make_result(K_DONE));
                  phase_in = PH_IGNORE;
               end
            end else begin
               pixel_byte_index_in = pixel_byte_index_ff + 2'd1;
            end
         end
         PH_IGNORE: ;
         default: ;
      endcase

      if (end_of_file) begin
         if (phase_in != PH_IGNORE) begin
            push = append(push, make_result(K_TRUNCATED));
         end
         phase_in            = PH_HEADER;
         header_index_in     = '0;
         pixel_byte_index_in = '0;
      end

      if (!take) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_HEADER;
         header_index_ff     <= '0;
         id_remaining_ff     <= '0;
         color_map_kind_ff   <= '0;
         image_kind_ff       <= '0;
         width_ff            <= '0;
         height_ff           <= '0;
         depth_bits_ff       <= '0;
         pixels_remaining_ff <= '0;
         pixel_byte_index_ff <= '0;
      end else if (take) begin
         phase_ff            <= phase_in;
         header_index_ff     <= header_index_in;
         id_remaining_ff     <= id_remaining_in;
         color_map_kind_ff   <= color_map_kind_in;
         image_kind_ff       <= image_kind_in;
         width_ff            <= width_in;
         height_ff           <= height_in;
         depth_bits_ff       <= depth_bits_in;
         pixels_remaining_ff <= pixels_remaining_in;
         pixel_byte_index_ff <= pixel_byte_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && store_pixel) begin
         pixel_bytes_ff[pixel_byte_index_ff] <= file_byte;
      end
   end

   `TGA_ASSERT_IMPL(a_pixels_left, clock, reset, phase_ff == PH_PIXELS, pixels_remaining_ff != 32'd0)
   `TGA_ASSERT_IMPL(a_pixel_depth, clock, reset, phase_ff == PH_PIXELS, depth_bits_ff == DEPTH_RGB || depth_bits_ff == DEPTH_RGBA)
   `TGA_ASSERT_ALWAYS(a_header_range, clock, reset, header_index_ff <= 5'(HEADER_LAST))
   `TGA_ASSERT_NEXT(a_eof_restart, clock, reset, take && end_of_file, phase_ff == PH_HEADER && header_index_ff == 5'd0)

endmodule

// ----- src/tga_result_fifo.sv -----
// Four-entry result queue: takes up to two words per cycle, gives one per cycle while out_ready is high.
`include "tga_truecolor_to_rgba_stream_assert.svh"
module tga_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  tga_pkg::push_type   push,
   output logic                has_room,
   output logic                out_valid,
   input  logic                out_ready,
   output tga_pkg::result_type out_data
);
   import tga_pkg::*;

   localparam int unsigned PtrBits = $clog2(QUEUE_DEPTH);

   result_type            entry_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]      count_ff, count_in;
   logic                  pop;

   // Room for the worst case of two results from the next word.
   assign has_room  = (count_ff <= (PtrBits + 1)'(QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrBits'(push.count);
      rd_ptr_in = rd_ptr_ff + PtrBits'(pop);
      count_in  = count_ff + (PtrBits + 1)'(push.count) - (PtrBits + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PtrBits'(1)] <= push.second;
      end
   end

   `TGA_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= (PtrBits + 1)'(QUEUE_DEPTH))
   `TGA_ASSERT_IMPL(a_push_room, clock, reset, push.count != 2'd0, has_room)

endmodule

// ----- src/tga_truecolor_to_rgba_stream.sv -----
// Top level of the streaming TGA true-color to RGBA decoder.
// Accepts one file byte per cycle while req_ready is high and answers with header,
// pixel and status words. A byte that yields one result or none keeps the full rate
// of one byte per cycle while rsp_ready is high. Bytes that yield two results (the
// last pixel or a header followed by done, or a header or an earlier pixel followed
// by truncated at end of file) leave an extra word that the four-entry result queue
// absorbs; req_ready is high whenever that queue holds two words or fewer. Results
// pass through that queue to rsp_. Only uncompressed true-color images without a
// color map at 24 or 32 bits per pixel are decoded; alpha is 0xff for 24-bit data.
module tga_truecolor_to_rgba_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_file_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic        rsp_final_pixel
);
   import tga_pkg::*;

   push_type   push;
   result_type head;
   logic       take;

   assign take = req_valid && req_ready;

   tga_decode_core u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .file_byte   (req_file_byte),
      .end_of_file (req_end_of_file),
      .push        (push)
   );

   tga_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_red          = head.red;
   assign rsp_green        = head.green;
   assign rsp_blue         = head.blue;
   assign rsp_alpha        = head.alpha;
   assign rsp_image_width  = head.image_width;
   assign rsp_image_height = head.image_height;
   assign rsp_final_pixel  = head.final_pixel;

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the streaming TGA true-color to RGBA decoder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tga_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_BYTES = 660;
   localparam int HOLD_CYCLES = 100;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       drain;
   } file_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_file_byte = 8'h00;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic        rsp_final_pixel;

   file_word_type file_words[$];
   result_type    pending_results[$];

   // decoder state as the byte stream implies it
   phase_type   dec_phase = PH_HEADER;
   logic [4:0]  hdr_pos = '0;
   logic [7:0]  id_left = '0;
   logic [7:0]  map_field = '0;
   logic [7:0]  type_field = '0;
   logic [15:0] img_w = '0;
   logic [15:0] img_h = '0;
   logic [7:0]  depth_field = '0;
   logic [31:0] px_left = '0;
   logic [1:0]  px_pos = '0;
   logic [7:0]  px_store [3];

   int  error_count = 0;
   int  file_count = 0;
   int  bytes_total = 0;
   int  bytes_accepted = 0;
   int  results_checked = 0;
   int  kind_count [5] = '{default: 0};
   int  holds_done = 0;
   int  idle_cycles = 0;
   bit  byte_taken = 1'b0;
   int  burst_left = 8;
   int  gap_left = 0;
   int  hold_left = 0;
   int  next_hold_at = 40;
   int  rx_mode = 0;
   int  mode_left = 0;
   int  rx_tick = 0;

   tga_truecolor_to_rgba_stream DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_file_byte    (req_file_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_final_pixel  (rsp_final_pixel)
   );

   task automatic report_error(input string msg);
      $display("%0t ERROR %s", $realtime, msg);
      error_count++;
   endtask

   function automatic result_type make_word(input kind_type k, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [7:0] a, input logic [15:0] w,
                                            input logic [15:0] h, input logic f);
      result_type res;
      res.kind = k;
      res.red = r;
      res.green = g;
      res.blue = b;
      res.alpha = a;
      res.image_width = w;
      res.image_height = h;
      res.final_pixel = f;
      return res;
   endfunction

   // Advance the decoder by one file byte and queue the words it should emit.
   task automatic decode_byte(input logic [7:0] data, input logic last);
      logic [1:0] last_pos;
      logic [7:0] alpha;
      bit         ok;
      case (dec_phase)
         PH_HEADER: begin
            case (hdr_pos)
               5'd0: id_left = data;
               5'd1: map_field = data;
               5'd2: type_field = data;
               5'd12: img_w[7:0] = data;
               5'd13: img_w[15:8] = data;
               5'd14: img_h[7:0] = data;
               5'd15: img_h[15:8] = data;
               5'd16: depth_field = data;
               default: ;
            endcase
            if (hdr_pos >= HEADER_LAST) begin
               hdr_pos = '0;
               ok = map_field == MAP_NONE && type_field == TYPE_TRUECOLOR &&
                    (depth_field == DEPTH_RGBA || depth_field == DEPTH_RGB);
               if (!ok) begin
                  pending_results.push_back(make_word(K_UNSUPPORTED, 0, 0, 0, 0, 0, 0, 0));
                  dec_phase = PH_IGNORE;
               end else begin
                  pending_results.push_back(make_word(K_HEADER, 0, 0, 0, 0, img_w, img_h, 0));
                  px_left = 32'(img_w) * 32'(img_h);
                  px_pos = '0;
                  if (id_left != 0) begin
                     dec_phase = PH_ID;
                  end else if (px_left != 0) begin
                     dec_phase = PH_PIXELS;
                  end else begin
                     pending_results.push_back(make_word(K_DONE, 0, 0, 0, 0, 0, 0, 0));
                     dec_phase = PH_IGNORE;
                  end
               end
            end else begin
               hdr_pos = hdr_pos + 5'd1;
            end
         end
         PH_ID: begin
            id_left = id_left - 8'd1;
            if (id_left == 0) begin
               if (px_left != 0) begin
                  dec_phase = PH_PIXELS;
               end else begin
                  pending_results.push_back(make_word(K_DONE, 0, 0, 0, 0, 0, 0, 0));
                  dec_phase = PH_IGNORE;
               end
            end
         end
         PH_PIXELS: begin
            last_pos = (depth_field == DEPTH_RGBA) ? 2'd3 : 2'd2;
            if (px_pos < 2'd3) px_store[px_pos] = data;
            if (px_pos >= last_pos) begin
               alpha = (depth_field == DEPTH_RGBA) ? data : OPAQUE;
               // stored order is blue, green, red
               pending_results.push_back(make_word(K_PIXEL, px_store[2], px_store[1],
                                                   px_store[0], alpha, 0, 0, px_left == 1));
               px_pos = '0;
               px_left = px_left - 32'd1;
               if (px_left == 0) begin
                  pending_results.push_back(make_word(K_DONE, 0, 0, 0, 0, 0, 0, 0));
                  dec_phase = PH_IGNORE;
               end
            end else begin
               px_pos = px_pos + 2'd1;
            end
         end
         default: ;
      endcase
      if (last) begin
         if (dec_phase != PH_IGNORE)
            pending_results.push_back(make_word(K_TRUNCATED, 0, 0, 0, 0, 0, 0, 0));
         dec_phase = PH_HEADER;
         hdr_pos = '0;
         px_pos = '0;
      end
   endtask

   task automatic push_byte(input logic [7:0] data, input bit last, input bit drain);
      file_word_type word;
      word.data = data;
      word.last = last;
      word.drain = drain;
      file_words.push_back(word);
   endtask

   // Queue one file. cut: 0 random cut, >0 and short of the file cut there, else whole file plus trailing bytes.
   task automatic push_file(input int id_len, input logic [7:0] cmap,
                            input logic [7:0] img_type, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] depth, input int cut,
                            input int trailing, input int fill, input bit drain);
      longint     body;
      longint     full;
      longint     stop;
      logic [7:0] data;
      bit         good;
      good = cmap == MAP_NONE && img_type == TYPE_TRUECOLOR &&
             (depth == DEPTH_RGB || depth == DEPTH_RGBA);
      body = good ? id_len + longint'(w) * longint'(h) * ((depth == DEPTH_RGBA) ? 4 : 3) : 0;
      full = 18 + body;
      if (cut == 0)
         stop = $urandom_range(1, int'(full));
      else if (cut > 0 && cut < full)
         stop = cut;
      else
         stop = full + trailing;
      for (longint i = 0; i < stop; i++) begin
         case (i)
            0: data = id_len[7:0];
            1: data = cmap;
            2: data = img_type;
            12: data = w[7:0];
            13: data = w[15:8];
            14: data = h[7:0];
            15: data = h[15:8];
            16: data = depth;
            default: begin
               if (fill < 0 || i < 18 + id_len || i >= full)
                  data = 8'($urandom_range(0, 255));
               else
                  data = fill[7:0];
            end
         endcase
         push_byte(data, i == stop - 1, drain && i == 0);
      end
      file_count++;
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   // sender: bursts of words separated by idle gaps
   always @(negedge clock) begin : drive_proc
      bit            offer;
      file_word_type word;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         byte_taken = 1'b0;
         offer = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (file_words.size() > 0 &&
                      !(file_words[0].drain && pending_results.size() > 0)) begin
            word = file_words.pop_front();
            req_file_byte <= word.data;
            req_end_of_file <= word.last;
            offer = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               if ($urandom_range(0, 5) == 0) begin
                  burst_left = $urandom_range(50, 150);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_valid <= offer;
      end
   end

   // receiver: changing stall patterns plus an occasional long hold-off
   always @(negedge clock) begin : receive_proc
      bit ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_tick++;
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else if (results_checked >= next_hold_at) begin
            hold_left = HOLD_CYCLES - 1;
            next_hold_at += 400;
            holds_done++;
            ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end else begin
               mode_left--;
            end
            case (rx_mode)
               0: ready = 1'b1;
               1: ready = $urandom_range(0, 1);
               2: ready = $urandom_range(0, 3) != 0;
               default: ready = (rx_tick % 5) != 4;
            endcase
         end
         rsp_ready <= ready;
      end
   end

   // check the word leaving first, then predict from the byte entering
   always @(posedge clock) begin : observe_proc
      result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_kind <= K_DONE) kind_count[rsp_kind]++;
            if (pending_results.size() == 0) begin
               report_error($sformatf("unexpected word of kind %0d", rsp_kind));
            end else begin
               want = pending_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_error($sformatf("word %0d kind: got %0d, expected %0d",
                                         results_checked, rsp_kind, want.kind));
               if (rsp_red !== want.red)
                  report_error($sformatf("word %0d red: got %0h, expected %0h",
                                         results_checked, rsp_red, want.red));
               if (rsp_green !== want.green)
                  report_error($sformatf("word %0d green: got %0h, expected %0h",
                                         results_checked, rsp_green, want.green));
               if (rsp_blue !== want.blue)
                  report_error($sformatf("word %0d blue: got %0h, expected %0h",
                                         results_checked, rsp_blue, want.blue));
               if (rsp_alpha !== want.alpha)
                  report_error($sformatf("word %0d alpha: got %0h, expected %0h",
                                         results_checked, rsp_alpha, want.alpha));
               if (rsp_image_width !== want.image_width)
                  report_error($sformatf("word %0d width: got %0d, expected %0d",
                                         results_checked, rsp_image_width, want.image_width));
               if (rsp_image_height !== want.image_height)
                  report_error($sformatf("word %0d height: got %0d, expected %0d",
                                         results_checked, rsp_image_height,
                                         want.image_height));
               if (rsp_final_pixel !== want.final_pixel)
                  report_error($sformatf("word %0d final pixel: got %0b, expected %0b",
                                         results_checked, rsp_final_pixel, want.final_pixel));
            end
            results_checked++;
         end
         if (req_valid && req_ready) begin
            decode_byte(req_file_byte, req_end_of_file);
            byte_taken = 1'b1;
            bytes_accepted++;
         end
      end
   end

   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : main_proc
      int         pick;
      int         id_len;
      int         len;
      logic [7:0] cmap;
      logic [7:0] img_type;
      logic [7:0] depth;
      logic [15:0] w;
      logic [15:0] h;
      bit         drain;
      bit         first;
      int         directed_bytes;

      // directed files
      push_file(0, MAP_NONE, TYPE_TRUECOLOR, 1, 1, DEPTH_RGB, -1, 2, 8'h00, 0);
      push_file(3, MAP_NONE, TYPE_TRUECOLOR, 2, 1, DEPTH_RGBA, -1, 0, 8'hff, 0);
      push_file(0, 8'd1, TYPE_TRUECOLOR, 1, 1, DEPTH_RGB, -1, 3, -1, 0);
      push_file(0, MAP_NONE, 8'd10, 1, 1, DEPTH_RGB, -1, 2, -1, 0);
      push_file(0, MAP_NONE, TYPE_TRUECOLOR, 1, 1, 8'd16, -1, 2, -1, 0);
      // empty images: header and done together, and done after the ID field
      push_file(0, MAP_NONE, TYPE_TRUECOLOR, 0, 5, DEPTH_RGB, -1, 1, -1, 0);
      push_file(2, MAP_NONE, TYPE_TRUECOLOR, 16'hffff, 0, DEPTH_RGBA, -1, 0, -1, 0);
      push_file(255, MAP_NONE, TYPE_TRUECOLOR, 0, 16'hffff, DEPTH_RGB, -1, 0, -1, 0);
      // short files: inside header, inside ID field, on its last byte, at header end
      push_file(0, MAP_NONE, TYPE_TRUECOLOR, 1, 1, DEPTH_RGB, 5, 0, -1, 1);
      push_file(4, MAP_NONE, TYPE_TRUECOLOR, 1, 1, DEPTH_RGB, 20, 0, -1, 0);
      push_file(2, MAP_NONE, TYPE_TRUECOLOR, 1, 1, DEPTH_RGB, 20, 0, -1, 0);
      push_file(2, MAP_NONE, TYPE_TRUECOLOR, 0, 1, DEPTH_RGB, -1, 0, -1, 0);
      push_file(0, MAP_NONE, TYPE_TRUECOLOR, 2, 2, DEPTH_RGB, 18, 0, -1, 0);
      push_file(0, MAP_NONE, 8'd3, 2, 2, DEPTH_RGB, 18, 0, -1, 0);
      push_byte(8'($urandom_range(0, 255)), 1, 0);
      file_count++;
      // cut inside a pixel, and after two whole pixels of the largest image
      push_file(0, MAP_NONE, TYPE_TRUECOLOR, 3, 2, DEPTH_RGBA, 24, 0, -1, 0);
      push_file(0, MAP_NONE, TYPE_TRUECOLOR, 16'hffff, 16'hffff, DEPTH_RGBA, 26, 0, -1, 0);
      directed_bytes = file_words.size();

      first = 1'b1;
      while (file_words.size() < directed_bytes + RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         depth = $urandom_range(0, 1) ? DEPTH_RGBA : DEPTH_RGB;
         id_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
         w = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
         h = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
         drain = first || $urandom_range(0, 24) == 0;
         first = 1'b0;
         if (pick < 65) begin
            push_file(id_len, MAP_NONE, TYPE_TRUECOLOR, w, h, depth, -1,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0, -1, drain);
         end else if (pick < 80) begin
            push_file(id_len, MAP_NONE, TYPE_TRUECOLOR, w, h, depth, 0, 0, -1, drain);
         end else if (pick < 92) begin
            cmap = MAP_NONE;
            img_type = TYPE_TRUECOLOR;
            case ($urandom_range(0, 2))
               0: cmap = 8'($urandom_range(1, 255));
               1: do img_type = 8'($urandom); while (img_type == TYPE_TRUECOLOR);
               default: do depth = 8'($urandom); while (depth == DEPTH_RGB || depth == DEPTH_RGBA);
            endcase
            push_file(id_len, cmap, img_type, w, h, depth,
                      ($urandom_range(0, 3) == 0) ? 0 : -1, $urandom_range(0, 10), -1, drain);
         end else begin
            // noise: random bytes ending the file
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
               push_byte(8'($urandom_range(0, 255)), i == len - 1, drain && i == 0);
            file_count++;
         end
      end
      bytes_total = file_words.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_accepted < bytes_total) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (pending_results.size() != 0)
         report_error($sformatf("%0d words never arrived", pending_results.size()));
      $display("run covered %0d files in %0d bytes, %0d result words, %0d long hold-offs",
               file_count, bytes_accepted, results_checked, holds_done);
      $display("words by kind: header %0d pixel %0d unsupported %0d truncated %0d done %0d",
               kind_count[K_HEADER], kind_count[K_PIXEL], kind_count[K_UNSUPPORTED],
               kind_count[K_TRUNCATED], kind_count[K_DONE]);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/tga_pkg.sv
src/tga_decode_core.sv
src/tga_result_fifo.sv
src/tga_truecolor_to_rgba_stream.sv
verif/tb_top.sv
